// ----- hdl/jsd_pkg.sv -----
package jsd_pkg;

  // Field widths of the job and result transfers
  localparam int unsigned DlW  = 8;
  localparam int unsigned PrW  = 16;
  localparam int unsigned SumW = 24;

  // Default capacity
  localparam int unsigned MaxJobsDef     = 256;
  localparam int unsigned MaxDeadlineDef = 255;

endpackage

// ----- hdl/jsd_job_mem.sv -----
module jsd_job_mem #(
  parameter int unsigned MAX_JOBS = 256,
  parameter int unsigned IW       = $clog2(MAX_JOBS)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IW-1:0]           waddr_i,
  input  logic [jsd_pkg::DlW-1:0] wdl_i,
  input  logic [jsd_pkg::PrW-1:0] wpr_i,
  input  logic [IW-1:0]           raddr_i,
  output logic [jsd_pkg::DlW-1:0] rdl_o,
  output logic [jsd_pkg::PrW-1:0] rpr_o
);
  import jsd_pkg::*;

  logic [DlW-1:0] dl_mem [MAX_JOBS];
  logic [PrW-1:0] pr_mem [MAX_JOBS];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dl_mem[waddr_i] <= wdl_i;
      pr_mem[waddr_i] <= wpr_i;
    end
    rdl_o <= dl_mem[raddr_i];
    rpr_o <= pr_mem[raddr_i];
  end

endmodule

// ----- hdl/jsd_slot_mem.sv -----
module jsd_slot_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned SW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [SW-1:0] waddr_i,
  input  logic [SW-1:0] wdata_i,
  input  logic [SW-1:0] raddr_i,
  output logic [SW-1:0] rdata_o
);
  import jsd_pkg::*;

  // union-find parent table
  logic [SW-1:0] par_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      par_mem[waddr_i] <= wdata_i;
    end
    rdata_o <= par_mem[raddr_i];
  end

endmodule

// ----- hdl/job_sequencing_deadlines.sv -----
// Job sequencing with deadlines. Jobs (deadline, profit) are taken one per
// cycle until a transfer with last_i set; that job belongs to the set. Jobs
// beyond MAX_JOBS are dropped. The block then orders the jobs by profit,
// highest first, ties by earlier deadline, and places each in the latest
// free slot at or before its deadline (clamped to MAX_DEADLINE) using a
// union-find parent table; deadline 0 is never placed. One result carries
// the saturated sum of placed profits. Work per set: one selection pass per
// stored job, each scanning all stored jobs one at a time through the single
// job memory read port (a read state, then a compare state), then a walk of
// the parent table (a read state, then a check state per lookup); then the
// total goes to the output register (held while an earlier total is still
// waiting there) and a clearing pass of the parent table over slots 0 to
// MAX_DEADLINE (also run after reset). in_stall_o is high all that time.
module job_sequencing_deadlines #(
  parameter int unsigned MAX_JOBS     = jsd_pkg::MaxJobsDef,
  parameter int unsigned MAX_DEADLINE = jsd_pkg::MaxDeadlineDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [jsd_pkg::DlW-1:0]  deadline_i,
  input  logic [jsd_pkg::PrW-1:0]  profit_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [jsd_pkg::SumW-1:0] total_profit_o
);
  import jsd_pkg::*;

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned SW = $clog2(MAX_DEADLINE + 1);
  localparam int unsigned KW = PrW + DlW + IW;

  typedef enum logic [2:0] {
    S_CLEAR, S_LOAD, S_SCAN_RD, S_SCAN_CMP, S_FIND_RD, S_FIND_CHK, S_DONE
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q, pass_q;
  logic [IW-1:0]   idx_q;
  logic [SW-1:0]   clr_q, r_q;
  logic [KW-1:0]   best_q, prev_q;
  logic            have_q, first_q;
  logic [SumW-1:0] sum_q;
  logic            out_valid_q;
  logic [SumW-1:0] out_q;

  logic [DlW-1:0]  rdl;
  logic [PrW-1:0]  rpr;
  logic [SW-1:0]   par;
  logic            in_xfer;
  logic [KW-1:0]   cand, best_n;
  logic            take;
  logic [DlW-1:0]  sel_dl;
  logic [SW-1:0]   sel_slot;
  logic [SumW:0]   sum_ext;
  logic            slot_we;
  logic [SW-1:0]   slot_waddr, slot_wdata, slot_raddr;

  assign in_stall_o     = (state_q != S_LOAD);
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign total_profit_o = out_q;

  jsd_job_mem #(.MAX_JOBS(MAX_JOBS), .IW(IW)) u_job_mem (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (cnt_q < CW'(MAX_JOBS))),
    .waddr_i (cnt_q[IW-1:0]),
    .wdl_i   (deadline_i),
    .wpr_i   (profit_i),
    .raddr_i (idx_q),
    .rdl_o   (rdl),
    .rpr_o   (rpr)
  );

  // parent table port mux: clearing pass or link of a taken slot
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = r_q;
    slot_wdata = r_q - SW'(1);
    if (state_q == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_q;
      slot_wdata = clr_q;
    end else if (state_q == S_FIND_CHK && par == r_q && r_q != '0) begin
      slot_we = 1'b1;
    end
  end
  assign slot_raddr = r_q;

  jsd_slot_mem #(.DEPTH(MAX_DEADLINE + 1), .SW(SW)) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (par)
  );

  // selection key: higher profit, then lower deadline, then lower index wins
  always_comb begin
    cand   = {rpr, ~rdl, ~idx_q};
    take   = (first_q || cand < prev_q) && (!have_q || cand > best_q);
    best_n = take ? cand : best_q;
    sel_dl = ~best_n[IW +: DlW];
    if (32'(sel_dl) > MAX_DEADLINE) begin
      sel_slot = SW'(MAX_DEADLINE);
    end else begin
      sel_slot = SW'(sel_dl);
    end
    sum_ext = {1'b0, sum_q} + (SumW + 1)'(prev_q[KW-1 -: PrW]);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pass_q      <= '0;
      idx_q       <= '0;
      clr_q       <= '0;
      r_q         <= '0;
      best_q      <= '0;
      prev_q      <= '0;
      have_q      <= 1'b0;
      first_q     <= 1'b1;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(MAX_DEADLINE)) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (in_xfer) begin
            if (cnt_q < CW'(MAX_JOBS)) begin
              cnt_q <= cnt_q + CW'(1);
            end
            if (last_i) begin
              idx_q   <= '0;
              pass_q  <= '0;
              have_q  <= 1'b0;
              first_q <= 1'b1;
              sum_q   <= '0;
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (CW'(idx_q) + CW'(1) == cnt_q) begin
            prev_q  <= best_n;
            first_q <= 1'b0;
            have_q  <= 1'b0;
            r_q     <= sel_slot;
            state_q <= S_FIND_RD;
          end else begin
            best_q  <= best_n;
            have_q  <= have_q || take;
            idx_q   <= idx_q + IW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_FIND_RD: begin
          state_q <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (par != r_q) begin
            r_q     <= par;
            state_q <= S_FIND_RD;
          end else begin
            if (r_q != '0) begin
              sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            end
            pass_q <= pass_q + CW'(1);
            idx_q  <= '0;
            if (pass_q + CW'(1) == cnt_q) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_q       <= sum_q;
            cnt_q       <= '0;
            sum_q       <= '0;
            clr_q       <= '0;
            state_q     <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import jsd_pkg::*;

  localparam int unsigned JobCap   = MaxJobsDef;
  localparam int unsigned SlotTop  = MaxDeadlineDef;
  localparam int unsigned SumSat   = 24'hFFFFFF;
  localparam int unsigned IdleLimit = 600000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DlW-1:0]    deadline_i;
  logic [PrW-1:0]    profit_i;
  logic              last_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SumW-1:0]   total_profit_o;

  // jobs of the set being loaded, as seen by the predictor
  bit [DlW-1:0]  set_dl_q[$];
  bit [PrW-1:0]  set_pr_q[$];
  // predicted totals waiting for their result transfer
  bit [SumW-1:0] total_q[$];
  int unsigned   slot_par[SlotTop+1];

  int  errors;
  int  jobs_sent;
  int  totals_seen;
  int  idle_cycles;
  bit  no_gaps;
  bit  hold_req;

  job_sequencing_deadlines uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .deadline_i    (deadline_i),
    .profit_i      (profit_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .total_profit_o(total_profit_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // order: higher profit first, then earlier deadline
  function automatic bit job_ahead(int unsigned x, int unsigned y);
    if (set_pr_q[x] != set_pr_q[y]) return set_pr_q[x] > set_pr_q[y];
    return set_dl_q[x] < set_dl_q[y];
  endfunction

  // root of a slot, with path compression
  function automatic int unsigned free_slot(int unsigned s);
    int unsigned r;
    int unsigned nxt;
    r = s;
    while (slot_par[r] != r) r = slot_par[r];
    while (slot_par[s] != r) begin
      nxt = slot_par[s];
      slot_par[s] = r;
      s = nxt;
    end
    return r;
  endfunction

  // total profit of the placed jobs of the loaded set
  function automatic bit [SumW-1:0] schedule_profit();
    int unsigned ord[JobCap];
    int unsigned n, i, j, key, d, r;
    int unsigned sum;
    n = set_dl_q.size();
    for (i = 0; i <= SlotTop; i++) slot_par[i] = i;
    for (i = 0; i < n; i++) begin
      key = i;
      j = i;
      while (j > 0 && job_ahead(key, ord[j-1])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    sum = 0;
    for (i = 0; i < n; i++) begin
      d = set_dl_q[ord[i]];
      if (d > SlotTop) d = SlotTop;
      r = free_slot(d);
      if (r > 0) begin
        sum += set_pr_q[ord[i]];
        if (sum > SumSat) sum = SumSat;
        slot_par[r] = free_slot(r - 1);
      end
    end
    return sum[SumW-1:0];
  endfunction

  // one job transfer; the predictor runs at the accepting edge
  task automatic send_job(bit [DlW-1:0] dl, bit [PrW-1:0] pr, bit lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    deadline_i <= dl;
    profit_i   <= pr;
    last_i     <= lst;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    jobs_sent++;
    if (set_dl_q.size() < JobCap) begin
      set_dl_q.push_back(dl);
      set_pr_q.push_back(pr);
    end
    if (lst) begin
      total_q.push_back(schedule_profit());
      set_dl_q.delete();
      set_pr_q.delete();
    end
  endtask

  task automatic quiet_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random set with deadlines crowded into a few slots when dense is set
  task automatic random_set(int unsigned n, bit dense);
    bit [DlW-1:0] dl;
    bit [PrW-1:0] pr;
    for (int unsigned k = 0; k < n; k++) begin
      dl = dense ? DlW'($urandom_range(0, 12)) : DlW'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: pr = PrW'($urandom_range(0, 7));
        1: pr = PrW'(16'hFFFF - $urandom_range(0, 3));
        default: pr = PrW'($urandom);
      endcase
      send_job(dl, pr, k == n - 1);
    end
  endtask

  task automatic test_directed();
    // lone job with deadline zero earns nothing
    send_job(8'd0, 16'hFFFF, 1'b1);
    // lone extreme job
    send_job(8'd255, 16'hFFFF, 1'b1);
    send_job(8'd1, 16'd0, 1'b1);
    // mostly slot 1, plus a deadline-2 and a deadline-0 job; ties by earlier deadline
    send_job(8'd1, 16'd100, 1'b0);
    send_job(8'd1, 16'd300, 1'b0);
    send_job(8'd2, 16'd300, 1'b0);
    send_job(8'd1, 16'd300, 1'b0);
    send_job(8'd0, 16'd900, 1'b1);
    // classic mix with contention
    send_job(8'd2, 16'd100, 1'b0);
    send_job(8'd1, 16'd19, 1'b0);
    send_job(8'd2, 16'd27, 1'b0);
    send_job(8'd1, 16'd25, 1'b0);
    send_job(8'd3, 16'd15, 1'b1);
    // alternating bit patterns in both fields
    send_job(8'hAA, 16'h5555, 1'b0);
    send_job(8'h55, 16'hAAAA, 1'b0);
    send_job(8'h80, 16'h8000, 1'b0);
    send_job(8'h7F, 16'h7FFF, 1'b1);
  endtask

  // full set, last job arriving exactly at capacity; maximal sum
  task automatic test_full_set();
    for (int k = 0; k < JobCap; k++)
      send_job(DlW'(255 - (k % 3)), 16'hFFFF, k == JobCap - 1);
  endtask

  // jobs past capacity are dropped, last still triggers the work
  task automatic test_overflow_set();
    for (int k = 0; k < JobCap + 4; k++)
      send_job(DlW'($urandom_range(0, 255)), PrW'($urandom), k == JobCap + 3);
  endtask

  // receiver holds off while sender keeps offering sets
  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    for (int s = 0; s < 4; s++) random_set($urandom_range(1, 6), 1'b1);
    no_gaps = 1'b0;
  endtask

  // sender waits for every result before going on
  task automatic test_drain_pause();
    random_set(5, 1'b1);
    quiet_input();
    while (total_q.size() != 0) @(posedge clk_i);
    random_set(3, 1'b0);
  endtask

  task automatic test_random();
    int unsigned n;
    while (jobs_sent < 1800) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
      random_set(n, $urandom_range(0, 2) != 0);
    end
    no_gaps = 1'b0;
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    int w;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (2000) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        w = no_gaps ? 0 : $urandom_range(0, 7);
        if (w > 0) begin
          out_stall_i <= 1'b1;
          repeat (w) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      totals_seen++;
      if (total_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d", $time, total_profit_o);
      end else begin
        if (total_profit_o !== total_q[0]) begin
          errors++;
          $display("%0t: total_profit expected %0d, actual %0d",
                   $time, total_q[0], total_profit_o);
        end
        void'(total_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, total_q.size());
      $display("job_sequencing_deadlines: mismatch");
      $finish;
    end
  end

  initial begin
    in_valid_i = 1'b0;
    deadline_i = '0;
    profit_i   = '0;
    last_i     = 1'b0;
    errors = 0;
    jobs_sent = 0;
    totals_seen = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_full_set();
    test_overflow_set();
    test_random();
    quiet_input();
    while (total_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d jobs in sets of 1 to capacity plus overflow, checked %0d totals",
             jobs_sent, totals_seen);
    $display("with random gaps, a long result hold-off and a drain pause; %0d errors", errors);
    if (errors == 0 && total_q.size() == 0)
      $display("job_sequencing_deadlines: match");
    else
      $display("job_sequencing_deadlines: mismatch");
    $finish;
  end

endmodule
